@@ hw/rtl/signed_int_to_decimal_ascii_assert.svh @@
// Assertion macros for the signed integer to decimal ASCII converter.
// Used by modules that see clk and rst_n; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SIDTA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// Antecedent implies consequent in the next cycle.
`define SIDTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence check violated");

`endif

@@ hw/rtl/sidta_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`default_nettype none

package sidta_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  digit_t;
  typedef logic [7:0]  char_t;

  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  typedef logic [DIG_IDX_W-1:0] dig_idx_t;

  // ceil(2^35 / 10): exact quotient for every 32-bit dividend
  localparam word_t       RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam char_t ASCII_ZERO  = 8'd48;
  localparam char_t ASCII_NINE  = 8'd57;
  localparam char_t ASCII_MINUS = 8'd45;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_REM  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sidta_if.sv @@
// Valid/ready channel interfaces for the decimal ASCII converter.
// Depends on sidta_pkg.
`default_nettype none

interface sidta_in_if;
  logic              valid;
  logic              ready;
  sidta_pkg::word_t  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidta_out_if;
  logic              valid;
  logic              ready;
  sidta_pkg::char_t  ascii_char;
  logic              last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sidta_div10.sv @@
// Shared divide-by-ten unit: reciprocal multiply registered, remainder next cycle.
// Depends on sidta_pkg.
`default_nettype none

module sidta_div10 (
  input  wire               clk,
  input  wire               load,
  input  sidta_pkg::word_t  dividend,
  output sidta_pkg::word_t  quot,
  output sidta_pkg::digit_t rem
);
  import sidta_pkg::*;

  word_t       d_r;
  word_t       q_r;
  logic [63:0] prod;
  word_t       q_nxt;
  word_t       diff;

  assign prod  = {32'd0, dividend} * {32'd0, RECIP_10};
  assign q_nxt = word_t'(prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= dividend;
      q_r <= q_nxt;
    end
  end

  // q*10 as two shifts and an add
  assign diff = d_r - ((q_r << 3) + (q_r << 1));
  assign quot = q_r;
  assign rem  = diff[3:0];

endmodule

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text. Each accepted value produces
// its characters on the output channel, most significant first, with a
// leading '-' for negative values and last_char set on the final one. Digits
// are found least significant first by one shared divide-by-ten unit, in two
// steps per digit (reciprocal multiply, then remainder), and are held in a
// ten-entry digit store until emission. Characters are emitted one per cycle
// while the output is not stalled. The input is ready only while idle.
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
  input  wire          clk,
  input  wire          rst_n,
  sidta_in_if.sink     in_ch,
  sidta_out_if.source  out_ch
);
  import sidta_pkg::*;

  state_t   state_r, state_nxt;
  word_t    mag_r, mag_nxt;
  logic     neg_r, neg_nxt;
  dig_idx_t ndig_r, ndig_nxt;
  dig_idx_t rd_idx_r, rd_idx_nxt;
  logic     sign_pend_r, sign_pend_nxt;
  digit_t   digs_r [MAX_DIGITS];

  logic     out_valid_r, out_valid_nxt;
  char_t    out_char_r, out_char_nxt;
  logic     out_last_r, out_last_nxt;

  logic     div_load;
  word_t    div_quot;
  digit_t   div_rem;
  logic     dig_we;
  logic     out_free;
  logic     in_xfer;
  logic     out_char_ok;
  logic     out_is_minus;

  sidta_div10 u_div10 (
    .clk      (clk),
    .load     (div_load),
    .dividend (mag_r),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last_char  = out_last_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    sign_pend_nxt = sign_pend_r;
    div_load      = 1'b0;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_ch.value[31];
          // magnitude in an unsigned word covers the most negative value
          mag_nxt   = in_ch.value[31] ? (word_t'(0) - in_ch.value) : in_ch.value;
          ndig_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        div_load  = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        dig_we   = 1'b1;
        mag_nxt  = div_quot;
        ndig_nxt = ndig_r + dig_idx_t'(1);
        if (div_quot == '0) begin
          rd_idx_nxt    = ndig_r;
          sign_pend_nxt = neg_r;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ASCII_ZERO + char_t'(digs_r[rd_idx_r]);
            out_last_nxt = (rd_idx_r == '0);
            if (rd_idx_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              rd_idx_nxt = rd_idx_r - dig_idx_t'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    ndig_r      <= ndig_nxt;
    rd_idx_r    <= rd_idx_nxt;
    sign_pend_r <= sign_pend_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    if (dig_we) begin
      digs_r[ndig_r] <= div_rem;
    end
  end

  assign out_char_ok  = (out_char_r == ASCII_MINUS) ||
                        ((out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_NINE));
  assign out_is_minus = out_valid_r && (out_char_r == ASCII_MINUS);

  `SIDTA_ASSERT_ALWAYS(a_rem_decimal, (state_r != S_REM) || (div_rem <= digit_t'(9)))
  `SIDTA_ASSERT_ALWAYS(a_emit_idx_valid, (state_r != S_EMIT) || (rd_idx_r < ndig_r))
  `SIDTA_ASSERT_ALWAYS(a_char_legal, !out_valid_r || out_char_ok)
  `SIDTA_ASSERT_NEXT(a_sign_not_last, out_is_minus, !out_is_minus || !out_last_r)

endmodule

`default_nettype wire
